### hdl/svm_pkg.sv
// Shared constants, request codes and helpers for the sparse SVM update block.
package svm_pkg;

   localparam int NUM_FEATURES_DEF = 4096;
   localparam int MAX_ENTRIES_DEF  = 256;

   localparam int IDX_W  = 12;
   localparam int VAL_W  = 32;
   localparam int RATE_W = 25;
   localparam int RCP_W  = 25;

   localparam logic [RATE_W-1:0] RATE_RESET = 25'd167772;
   localparam int Q_SHIFT = 24;

   // request kinds
   localparam logic [1:0] REQ_ENTRY   = 2'd0;
   localparam logic [1:0] REQ_WR_WT   = 2'd1;
   localparam logic [1:0] REQ_RD_WT   = 2'd2;
   localparam logic [1:0] REQ_WR_RCP  = 2'd3;

   // response kinds
   localparam logic RSP_SAMPLE = 1'b0;
   localparam logic RSP_READ   = 1'b1;

   // clamp a shifted product to the signed 32-bit range
   function automatic logic signed [31:0] sat32(input logic signed [39:0] x);
      logic signed [39:0] hi;
      logic signed [39:0] lo;
      hi = 40'sd2147483647;
      lo = -40'sd2147483648;
      if (x > hi) begin
         sat32 = 32'sh7fffffff;
      end else if (x < lo) begin
         sat32 = 32'sh80000000;
      end else begin
         sat32 = x[31:0];
      end
   endfunction

endpackage

### hdl/sparse_svm_sgd_update.sv
// Top level of the sparse linear SVM hinge-loss SGD update engine.
//
// Usage: present one item on the req_ ports and raise start; the item is
// taken at a clock edge where start is high and busy is low. Kind 0 items
// are sample entries, buffered until the one marked last_entry. Kinds 1
// and 3 write a weight or a degree reciprocal; kind 2 reads a weight.
// Results leave on the rsp_ ports for a single cycle marked by rsp_valid;
// the receiver has no way to hold them off and must take them then.
// Stepping: an entry that is not last, and a weight or reciprocal write,
// are done at acceptance and leave busy low. A read goes through the
// S_RDWT state and then the response register. The last entry of a
// sample starts the dot product pass, which for each entry reads the
// buffer, then the weight memory, multiplies and accumulates, and then the
// update pass, which does the read-modify-write of one weight per entry
// through two multiply stages. An overflowed sample skips both passes.
// Reset: the weight memory is swept to zero, one entry per cycle, while
// busy stays high; csr writes are still taken. learning_rate returns to
// 167772. Reciprocals must be loaded before use.
module sparse_svm_sgd_update
   import svm_pkg::*;
#(
   parameter int NUM_FEATURES = NUM_FEATURES_DEF,
   parameter int MAX_ENTRIES  = MAX_ENTRIES_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [1:0]               req_type,
   input  logic [IDX_W-1:0]         req_feature_index,
   input  logic signed [VAL_W-1:0]  req_feature_value,
   input  logic signed [1:0]        req_sample_class,
   input  logic                     req_last_entry,
   input  logic signed [VAL_W-1:0]  req_write_data,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [RATE_W-1:0]        csr_learning_rate,
   output logic                     rsp_valid,
   output logic                     rsp_resp_kind,
   output logic signed [63:0]       rsp_margin,
   output logic                     rsp_hinge_active,
   output logic                     rsp_overflow,
   output logic signed [31:0]       rsp_read_data
);

   localparam int AW = $clog2(NUM_FEATURES);
   localparam int BW = $clog2(MAX_ENTRIES);
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int EW = IDX_W + VAL_W;

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_RDWT  = 4'd2;
   localparam logic [3:0] S_DBUF  = 4'd3;
   localparam logic [3:0] S_DWT   = 4'd4;
   localparam logic [3:0] S_DMUL  = 4'd5;
   localparam logic [3:0] S_DACC  = 4'd6;
   localparam logic [3:0] S_DFIN  = 4'd7;
   localparam logic [3:0] S_UBUF  = 4'd8;
   localparam logic [3:0] S_UWT   = 4'd9;
   localparam logic [3:0] S_UMUL  = 4'd10;
   localparam logic [3:0] S_UADD  = 4'd11;
   localparam logic [3:0] S_UPRD  = 4'd12;
   localparam logic [3:0] S_UWR   = 4'd13;

   function automatic logic in_range(input logic [IDX_W-1:0] idx);
      in_range = ({20'd0, idx} < 32'(NUM_FEATURES));
   endfunction

   // control state
   logic [3:0]         state_ff, state_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [CW-1:0]      ptr_ff, ptr_in;
   logic               ovf_ff, ovf_in;
   logic [AW-1:0]      clr_ff, clr_in;
   logic [RATE_W-1:0]  rate_ff, rate_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // datapath
   logic               cls_neg_ff, cls_neg_in;
   logic               hinge_ff, hinge_in;
   logic [IDX_W-1:0]   e_idx_ff, e_idx_in;
   logic signed [31:0] e_val_ff, e_val_in;
   logic               e_ok_ff, e_ok_in;
   logic signed [63:0] acc_ff, acc_in;
   logic signed [63:0] prod_ff, prod_in;
   logic signed [57:0] grad_ff, grad_in;
   logic [49:0]        rr_ff, rr_in;
   logic signed [31:0] w_ff, w_in;
   logic signed [35:0] wsum_ff, wsum_in;
   logic signed [27:0] shrink_ff, shrink_in;
   logic               kind_ff, kind_in;
   logic signed [63:0] margin_ff, margin_in;
   logic               hinge_out_ff, hinge_out_in;
   logic               ovf_out_ff, ovf_out_in;
   logic signed [31:0] rdata_ff, rdata_in;

   // memory ports
   logic               wt_we;
   logic [AW-1:0]      wt_waddr, wt_raddr;
   logic [31:0]        wt_wdata, wt_rdata;
   logic               rc_we;
   logic [RCP_W-1:0]   rc_rdata;
   logic               buf_we;
   logic [BW-1:0]      buf_waddr;
   logic [EW-1:0]      buf_rdata;

   logic               accept;
   logic [CW-1:0]      cnt_next;
   logic signed [63:0] margin_c;
   logic signed [58:0] grad_adj;
   logic signed [34:0] grad_sh;

   assign accept    = start && (state_ff == S_IDLE);
   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;

   // weight, reciprocal and entry memories
   svm_ram #(.DEPTH(NUM_FEATURES), .WIDTH(32)) u_wt (
      .clock   (clock),
      .wr_en   (wt_we),
      .wr_addr (wt_waddr),
      .wr_data (wt_wdata),
      .rd_addr (wt_raddr),
      .rd_data (wt_rdata)
   );

   svm_ram #(.DEPTH(NUM_FEATURES), .WIDTH(RCP_W)) u_rcp (
      .clock   (clock),
      .wr_en   (rc_we),
      .wr_addr (AW'(req_feature_index)),
      .wr_data (req_write_data[RCP_W-1:0]),
      .rd_addr (wt_raddr),
      .rd_data (rc_rdata)
   );

   svm_ram #(.DEPTH(MAX_ENTRIES), .WIDTH(EW)) u_buf (
      .clock   (clock),
      .wr_en   (buf_we),
      .wr_addr (buf_waddr),
      .wr_data ({req_feature_index, req_feature_value}),
      .rd_addr (ptr_ff[BW-1:0]),
      .rd_data (buf_rdata)
   );

   // sequencer and datapath next values
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      ptr_in       = ptr_ff;
      ovf_in       = ovf_ff;
      clr_in       = clr_ff;
      rate_in      = rate_ff;
      rsp_valid_in = 1'b0;
      cls_neg_in   = cls_neg_ff;
      hinge_in     = hinge_ff;
      e_idx_in     = e_idx_ff;
      e_val_in     = e_val_ff;
      e_ok_in      = e_ok_ff;
      acc_in       = acc_ff;
      prod_in      = prod_ff;
      grad_in      = grad_ff;
      rr_in        = rr_ff;
      w_in         = w_ff;
      wsum_in      = wsum_ff;
      shrink_in    = shrink_ff;
      kind_in      = kind_ff;
      margin_in    = margin_ff;
      hinge_out_in = hinge_out_ff;
      ovf_out_in   = ovf_out_ff;
      rdata_in     = rdata_ff;

      wt_we     = 1'b0;
      wt_waddr  = AW'(e_idx_ff);
      wt_wdata  = 32'd0;
      wt_raddr  = AW'(buf_rdata[EW-1:VAL_W]);
      rc_we     = 1'b0;
      buf_we    = 1'b0;
      buf_waddr = cnt_ff[BW-1:0];
      cnt_next  = cnt_ff + CW'(1);
      margin_c  = cls_neg_ff ? -acc_ff : acc_ff;
      grad_adj  = cls_neg_ff ? -59'(grad_ff) : 59'(grad_ff);
      grad_sh   = 35'(grad_adj >>> Q_SHIFT);

      if (csr_valid) begin
         rate_in = csr_learning_rate;
      end

      unique case (state_ff)
         S_CLEAR: begin
            wt_we    = 1'b1;
            wt_waddr = clr_ff;
            clr_in   = clr_ff + AW'(1);
            if (clr_ff == AW'(NUM_FEATURES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            wt_raddr = AW'(req_feature_index);
            if (accept) begin
               e_idx_in = req_feature_index;
               e_ok_in  = in_range(req_feature_index);
               case (req_type)
                  REQ_ENTRY: begin
                     if (cnt_ff < CW'(MAX_ENTRIES)) begin
                        buf_we = 1'b1;
                        cnt_in = cnt_next;
                     end else begin
                        ovf_in = 1'b1;
                     end
                     if (req_last_entry) begin
                        cls_neg_in = req_sample_class[1];
                        if (ovf_in) begin
                           rsp_valid_in = 1'b1;
                           kind_in      = RSP_SAMPLE;
                           margin_in    = 64'sd0;
                           hinge_out_in = 1'b0;
                           ovf_out_in   = 1'b1;
                           rdata_in     = 32'sd0;
                           cnt_in       = '0;
                           ovf_in       = 1'b0;
                        end else begin
                           acc_in   = 64'sd0;
                           ptr_in   = '0;
                           state_in = S_DBUF;
                        end
                     end
                  end
                  REQ_WR_WT: begin
                     wt_we    = in_range(req_feature_index);
                     wt_waddr = AW'(req_feature_index);
                     wt_wdata = req_write_data;
                  end
                  REQ_RD_WT: begin
                     state_in = S_RDWT;
                  end
                  default: begin
                     rc_we = in_range(req_feature_index);
                  end
               endcase
            end
         end
         S_RDWT: begin
            rsp_valid_in = 1'b1;
            kind_in      = RSP_READ;
            margin_in    = 64'sd0;
            hinge_out_in = 1'b0;
            ovf_out_in   = 1'b0;
            rdata_in     = e_ok_ff ? wt_rdata : 32'sd0;
            state_in     = S_IDLE;
         end
         // dot product pass
         S_DBUF: begin
            state_in = S_DWT;
         end
         S_DWT: begin
            e_idx_in = buf_rdata[EW-1:VAL_W];
            e_val_in = buf_rdata[VAL_W-1:0];
            e_ok_in  = in_range(buf_rdata[EW-1:VAL_W]);
            state_in = S_DMUL;
         end
         S_DMUL: begin
            prod_in  = e_ok_ff ? e_val_ff * $signed(wt_rdata) : 64'sd0;
            state_in = S_DACC;
         end
         S_DACC: begin
            acc_in = acc_ff + (prod_ff >>> Q_SHIFT);
            ptr_in = ptr_ff + CW'(1);
            state_in = (ptr_ff + CW'(1) == cnt_ff) ? S_DFIN : S_DBUF;
         end
         S_DFIN: begin
            acc_in   = margin_c;
            hinge_in = (margin_c < 64'sd16777216);
            ptr_in   = '0;
            state_in = S_UBUF;
         end
         // update pass, one weight at a time
         S_UBUF: begin
            state_in = S_UWT;
         end
         S_UWT: begin
            e_idx_in = buf_rdata[EW-1:VAL_W];
            e_val_in = buf_rdata[VAL_W-1:0];
            e_ok_in  = in_range(buf_rdata[EW-1:VAL_W]);
            state_in = S_UMUL;
         end
         S_UMUL: begin
            w_in     = wt_rdata;
            grad_in  = $signed({1'b0, rate_ff}) * e_val_ff;
            rr_in    = rate_ff * rc_rdata;
            state_in = S_UADD;
         end
         S_UADD: begin
            wsum_in   = 36'(w_ff) + (hinge_ff ? 36'(grad_sh) : 36'sd0);
            shrink_in = 28'sd16777216 - $signed({2'b00, rr_ff[49:Q_SHIFT]});
            state_in  = S_UPRD;
         end
         S_UPRD: begin
            prod_in  = wsum_ff * shrink_ff;
            state_in = S_UWR;
         end
         S_UWR: begin
            wt_we    = e_ok_ff;
            wt_wdata = sat32(40'(prod_ff >>> Q_SHIFT));
            ptr_in   = ptr_ff + CW'(1);
            if (ptr_ff + CW'(1) == cnt_ff) begin
               rsp_valid_in = 1'b1;
               kind_in      = RSP_SAMPLE;
               margin_in    = acc_ff;
               hinge_out_in = hinge_ff;
               ovf_out_in   = 1'b0;
               rdata_in     = 32'sd0;
               cnt_in       = '0;
               ovf_in       = 1'b0;
               state_in     = S_IDLE;
            end else begin
               state_in = S_UBUF;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cnt_ff       <= '0;
         ptr_ff       <= '0;
         ovf_ff       <= 1'b0;
         clr_ff       <= '0;
         rate_ff      <= RATE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         ptr_ff       <= ptr_in;
         ovf_ff       <= ovf_in;
         clr_ff       <= clr_in;
         rate_ff      <= rate_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cls_neg_ff   <= cls_neg_in;
      hinge_ff     <= hinge_in;
      e_idx_ff     <= e_idx_in;
      e_val_ff     <= e_val_in;
      e_ok_ff      <= e_ok_in;
      acc_ff       <= acc_in;
      prod_ff      <= prod_in;
      grad_ff      <= grad_in;
      rr_ff        <= rr_in;
      w_ff         <= w_in;
      wsum_ff      <= wsum_in;
      shrink_ff    <= shrink_in;
      kind_ff      <= kind_in;
      margin_ff    <= margin_in;
      hinge_out_ff <= hinge_out_in;
      ovf_out_ff   <= ovf_out_in;
      rdata_ff     <= rdata_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_resp_kind    = kind_ff;
   assign rsp_margin       = margin_ff;
   assign rsp_hinge_active = hinge_out_ff;
   assign rsp_overflow     = ovf_out_ff;
   assign rsp_read_data    = rdata_ff;

endmodule

### hdl/svm_ram.sv
// Simple dual-port synchronous RAM with a registered read port.
module svm_ram #(
   parameter int DEPTH  = 4096,
   parameter int WIDTH  = 32,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
